/* design/u2rgb_pkg.sv */
// u2rgb_pkg: types, constants and helpers shared by the UYVY to RGB pair converter.
// No dependencies.
`timescale 1ns / 1ps

package u2rgb_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CB_BLUE  = 2'd0,
		REG_CR_RED   = 2'd1,
		REG_CB_GREEN = 2'd2,
		REG_CR_GREEN = 2'd3
	} cfg_reg_t;

	localparam logic [8:0] RST_CB_BLUE  = 9'd454;
	localparam logic [8:0] RST_CR_RED   = 9'd359;
	localparam logic [7:0] RST_CB_GREEN = 8'd88;
	localparam logic [7:0] RST_CR_GREEN = 8'd183;

	typedef struct packed {
		logic [8:0] cb_blue;
		logic [8:0] cr_red;
		logic [7:0] cb_green;
		logic [7:0] cr_green;
	} weights_t;

	// floored chroma terms, shared by both pixels
	typedef struct packed {
		logic signed [9:0] db;
		logic signed [9:0] er;
		logic signed [9:0] g;
	} chroma_terms_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic out;
	} stage_en_t;

	function automatic logic [7:0] sat_byte(input logic signed [10:0] v);
		logic [7:0] r;
		if (v[10]) begin
			r = 8'd0;
		end else if (v[9:8] != 2'b00) begin
			r = 8'hFF;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

/* design/u2rgb_in_if.sv */
// u2rgb_in_if: valid/ready channel carrying one UYVY group.
// No dependencies.
`timescale 1ns / 1ps

interface u2rgb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] chroma_blue;
	logic [7:0] luma_first;
	logic [7:0] chroma_red;
	logic [7:0] luma_second;

	modport source (output valid, chroma_blue, luma_first, chroma_red, luma_second,
		input ready);
	modport sink (input valid, chroma_blue, luma_first, chroma_red, luma_second,
		output ready);
endinterface

/* design/u2rgb_out_if.sv */
// u2rgb_out_if: valid/ready channel carrying two RGB888 pixels.
// No dependencies.
`timescale 1ns / 1ps

interface u2rgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_first;
	logic [7:0] green_first;
	logic [7:0] blue_first;
	logic [7:0] red_second;
	logic [7:0] green_second;
	logic [7:0] blue_second;

	modport source (output valid, red_first, green_first, blue_first,
		red_second, green_second, blue_second, input ready);
	modport sink (input valid, red_first, green_first, blue_first,
		red_second, green_second, blue_second, output ready);
endinterface

/* design/u2rgb_chroma.sv */
// u2rgb_chroma: two-stage chroma term pipeline (weight products, then floor/sum).
// Depends on u2rgb_pkg.
`timescale 1ns / 1ps

module u2rgb_chroma
	import u2rgb_pkg::*;
(
	input  logic          clk,
	input  stage_en_t     en,
	input  weights_t      weights,
	input  logic [7:0]    chroma_blue,
	input  logic [7:0]    chroma_red,
	output chroma_terms_t terms
);

	logic signed [8:0]  d;
	logic signed [8:0]  e;
	logic signed [18:0] prod_b_s1;
	logic signed [18:0] prod_r_s1;
	logic signed [18:0] prod_gb_s1;
	logic signed [18:0] prod_gr_s1;
	logic signed [18:0] g_sum;
	chroma_terms_t      terms_s2;

	// offset binary minus 128
	assign d = {~chroma_blue[7], ~chroma_blue[7], chroma_blue[6:0]};
	assign e = {~chroma_red[7], ~chroma_red[7], chroma_red[6:0]};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_b_s1  <= $signed({1'b0, weights.cb_blue}) * d;
			prod_r_s1  <= $signed({1'b0, weights.cr_red}) * e;
			prod_gb_s1 <= $signed({2'b00, weights.cb_green}) * d;
			prod_gr_s1 <= $signed({2'b00, weights.cr_green}) * e;
		end
	end

	assign g_sum = prod_gb_s1 + prod_gr_s1;

	// all sums fit in 18 signed bits; arithmetic >> 8 is the floor
	always_ff @(posedge clk) begin
		if (en.s2) begin
			terms_s2.db <= prod_b_s1[17:8];
			terms_s2.er <= prod_r_s1[17:8];
			terms_s2.g  <= g_sum[17:8];
		end
	end

	assign terms = terms_s2;

endmodule

/* design/u2rgb_lane.sv */
// u2rgb_lane: one pixel lane; delays luma, adds or subtracts the chroma terms, saturates to RGB888.
// Depends on u2rgb_pkg.
`timescale 1ns / 1ps

module u2rgb_lane
	import u2rgb_pkg::*;
(
	input  logic          clk,
	input  stage_en_t     en,
	input  logic [7:0]    luma,
	input  chroma_terms_t terms,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue
);

	logic [7:0]         luma_s1;
	logic [7:0]         luma_s2;
	logic signed [10:0] y_ext;
	logic signed [10:0] r_sum;
	logic signed [10:0] g_sum;
	logic signed [10:0] b_sum;
	logic [7:0]         red_q;
	logic [7:0]         green_q;
	logic [7:0]         blue_q;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			luma_s1 <= luma;
		end
		if (en.s2) begin
			luma_s2 <= luma_s1;
		end
	end

	assign y_ext = $signed({3'b000, luma_s2});
	assign r_sum = y_ext + {terms.er[9], terms.er};
	assign g_sum = y_ext - {terms.g[9], terms.g};
	assign b_sum = y_ext + {terms.db[9], terms.db};

	always_ff @(posedge clk) begin
		if (en.out) begin
			red_q   <= sat_byte(r_sum);
			green_q <= sat_byte(g_sum);
			blue_q  <= sat_byte(b_sum);
		end
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule

/* design/uyvy_to_rgb_pair.sv */
// uyvy_to_rgb_pair: full-range BT.601 UYVY group to two RGB888 pixels.
// Depends on u2rgb_pkg, u2rgb_in_if, u2rgb_out_if, u2rgb_chroma, u2rgb_lane.
// Accepts one UYVY group per clock and delivers one pixel pair per clock while the
// output is not back-pressured. A group loads the product stage on its transfer edge,
// then the chroma term stage, then the output register, which presents the result.
// The four weight multipliers of the product stage set the clock period, not the rate.
// Every stage holds under back-pressure and empty stages fill, so the input keeps
// taking transfers while a result waits in the output register, until the product and
// chroma term stages are both full. Weights are written through the cfg port (index
// 0..3); the user must write them only while the pipeline is empty, the block does not enforce it.
`timescale 1ns / 1ps

module uyvy_to_rgb_pair
	import u2rgb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	u2rgb_in_if.sink              pix_in,
	u2rgb_out_if.source           pix_out
);

	weights_t      weights_q;
	chroma_terms_t terms;
	stage_en_t     en;
	logic          v_s1_q;
	logic          v_s2_q;
	logic          v_out_q;
	logic          ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q.cb_blue  <= RST_CB_BLUE;
			weights_q.cr_red   <= RST_CR_RED;
			weights_q.cb_green <= RST_CB_GREEN;
			weights_q.cr_green <= RST_CR_GREEN;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CB_BLUE:  weights_q.cb_blue  <= cfg_data;
				REG_CR_RED:   weights_q.cr_red   <= cfg_data;
				REG_CB_GREEN: weights_q.cb_green <= cfg_data[7:0];
				REG_CR_GREEN: weights_q.cr_green <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// stage moves when it holds data and the next stage is free or draining
	assign en.out       = v_s2_q && (!v_out_q || pix_out.ready);
	assign ready_s2     = !v_s2_q || !v_out_q || pix_out.ready;
	assign en.s2        = v_s1_q && ready_s2;
	assign pix_in.ready = !v_s1_q || ready_s2;
	assign en.s1        = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1_q <= 1'b1;
			end else if (en.s2) begin
				v_s1_q <= 1'b0;
			end
			if (en.s2) begin
				v_s2_q <= 1'b1;
			end else if (en.out) begin
				v_s2_q <= 1'b0;
			end
			if (en.out) begin
				v_out_q <= 1'b1;
			end else if (pix_out.ready) begin
				v_out_q <= 1'b0;
			end
		end
	end

	u2rgb_chroma u_chroma (
		.clk         (clk),
		.en          (en),
		.weights     (weights_q),
		.chroma_blue (pix_in.chroma_blue),
		.chroma_red  (pix_in.chroma_red),
		.terms       (terms)
	);

	u2rgb_lane u_lane_first (
		.clk   (clk),
		.en    (en),
		.luma  (pix_in.luma_first),
		.terms (terms),
		.red   (pix_out.red_first),
		.green (pix_out.green_first),
		.blue  (pix_out.blue_first)
	);

	u2rgb_lane u_lane_second (
		.clk   (clk),
		.en    (en),
		.luma  (pix_in.luma_second),
		.terms (terms),
		.red   (pix_out.red_second),
		.green (pix_out.green_second),
		.blue  (pix_out.blue_second)
	);

	assign pix_out.valid = v_out_q;

endmodule
